>>> rtl/tsd_pkg.sv
`default_nettype none
package tsd_pkg;

  localparam int unsigned OFS_W  = 9;
  localparam int unsigned SIZE_W = 33;

  localparam logic [OFS_W-1:0] LAST_OFS    = 9'd511;
  localparam logic [OFS_W-1:0] NAME_LEN    = 9'd100;
  localparam logic [OFS_W-1:0] SIZE_OFS    = 9'd124;
  localparam logic [OFS_W-1:0] SIZE_END    = 9'd135;  // offset + 11 digits
  localparam logic [7:0]       CHAR_ZERO   = 8'h30;
  localparam logic [7:0]       CHAR_SEVEN  = 8'h37;

  localparam logic [1:0] KIND_NAME = 2'd0;
  localparam logic [1:0] KIND_HDR  = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;
  localparam logic [1:0] KIND_END  = 2'd3;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_DATA   = 4'b0010,
    PH_PAD    = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        value;
    logic [SIZE_W-1:0] file_size;
    logic              file_last;
    logic              truncated;
  } out_item_t;

  // front -> queue
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } q_push_t;

  // queue -> back
  typedef struct packed {
    logic      valid;
    out_item_t item;
  } q_head_t;

endpackage
`default_nettype wire

>>> rtl/tsd_stream_if.sv
`default_nettype none
interface tsd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

>>> rtl/tsd_front.sv
`default_nettype none
module tsd_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  tsd_stream_if.sink         in_ch,
  input  wire logic          q_full,
  output tsd_pkg::q_push_t   push
);

  tsd_pkg::phase_t                    phase_r, phase_nxt;
  logic [tsd_pkg::OFS_W-1:0]          ofs_r, ofs_nxt;
  logic [tsd_pkg::SIZE_W-1:0]         left_r, left_nxt;
  logic [tsd_pkg::SIZE_W-1:0]         accum_r, accum_nxt;
  logic                               octal_open_r, octal_open_nxt;
  logic                               name_open_r, name_open_nxt;

  logic                               accept;
  logic [7:0]                         b;
  logic                               fin;
  logic [tsd_pkg::OFS_W-1:0]          ofs_inc;
  logic                               data_last;
  tsd_pkg::q_push_t                   res;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign b           = in_ch.payload.byte_value;
  assign fin         = in_ch.payload.final_byte;
  assign ofs_inc     = ofs_r + 1'b1;
  assign data_last   = (left_r == tsd_pkg::SIZE_W'(1));

  always_comb begin
    phase_nxt      = phase_r;
    ofs_nxt        = ofs_r;
    left_nxt       = left_r;
    accum_nxt      = accum_r;
    octal_open_nxt = octal_open_r;
    name_open_nxt  = name_open_r;
    res            = '0;

    unique case (phase_r)
      tsd_pkg::PH_HEADER: begin
        if (ofs_r == '0 && b == 8'h00) begin
          res.valid     = 1'b1;
          res.item.kind = tsd_pkg::KIND_END;
          phase_nxt     = tsd_pkg::PH_DONE;
        end else begin
          if (ofs_r < tsd_pkg::NAME_LEN && name_open_r) begin
            if (b == 8'h00) begin
              name_open_nxt = 1'b0;
            end else begin
              res.valid      = 1'b1;
              res.item.kind  = tsd_pkg::KIND_NAME;
              res.item.value = b;
            end
          end
          if (ofs_r >= tsd_pkg::SIZE_OFS && ofs_r < tsd_pkg::SIZE_END && octal_open_r) begin
            if (b >= tsd_pkg::CHAR_ZERO && b <= tsd_pkg::CHAR_SEVEN) begin
              accum_nxt = {accum_r[tsd_pkg::SIZE_W-4:0], b[2:0]};
            end else begin
              octal_open_nxt = 1'b0;
            end
          end
          if (ofs_r == tsd_pkg::LAST_OFS) begin
            res.valid          = 1'b1;
            res.item.kind      = tsd_pkg::KIND_HDR;
            res.item.value     = '0;
            res.item.file_size = accum_r;
            res.item.file_last = (accum_r == '0);
            res.item.truncated = fin && (accum_r != '0);
            ofs_nxt        = '0;
            accum_nxt      = '0;
            octal_open_nxt = 1'b1;
            name_open_nxt  = 1'b1;
            if (accum_r != '0) begin
              left_nxt  = accum_r;
              phase_nxt = tsd_pkg::PH_DATA;
            end
          end else begin
            ofs_nxt = ofs_inc;
          end
        end
      end
      tsd_pkg::PH_DATA: begin
        left_nxt           = left_r - 1'b1;
        res.valid          = 1'b1;
        res.item.kind      = tsd_pkg::KIND_DATA;
        res.item.value     = b;
        res.item.file_last = data_last;
        res.item.truncated = fin && !data_last;
        ofs_nxt            = ofs_inc;
        if (data_last) begin
          phase_nxt = (ofs_inc == '0) ? tsd_pkg::PH_HEADER : tsd_pkg::PH_PAD;
        end
      end
      tsd_pkg::PH_PAD: begin
        ofs_nxt = ofs_inc;
        if (ofs_inc == '0) begin
          phase_nxt = tsd_pkg::PH_HEADER;
        end
      end
      tsd_pkg::PH_DONE: begin
      end
      default: begin
        phase_nxt = tsd_pkg::PH_HEADER;
      end
    endcase

    // end of input: back to the reset state
    if (fin) begin
      phase_nxt      = tsd_pkg::PH_HEADER;
      ofs_nxt        = '0;
      left_nxt       = '0;
      accum_nxt      = '0;
      octal_open_nxt = 1'b1;
      name_open_nxt  = 1'b1;
    end
  end

  assign push.valid = accept && res.valid;
  assign push.item  = res.item;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= tsd_pkg::PH_HEADER;
      ofs_r        <= '0;
      left_r       <= '0;
      accum_r      <= '0;
      octal_open_r <= 1'b1;
      name_open_r  <= 1'b1;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      ofs_r        <= ofs_nxt;
      left_r       <= left_nxt;
      accum_r      <= accum_nxt;
      octal_open_r <= octal_open_nxt;
      name_open_r  <= name_open_nxt;
    end
  end

endmodule
`default_nettype wire

>>> rtl/tsd_queue.sv
`default_nettype none
module tsd_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tsd_pkg::q_push_t  push,
  input  wire logic              pop,
  output tsd_pkg::q_head_t       head,
  output logic                   full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  tsd_pkg::out_item_t mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               do_push, do_pop;

  assign full       = (cnt_r == CNT_W'(DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.item  = mem_r[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/tsd_back.sv
`default_nettype none
module tsd_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire tsd_pkg::q_head_t  head,
  output logic                   pop,
  tsd_stream_if.source           out_ch
);

  logic               valid_r;
  tsd_pkg::out_item_t item_r;
  logic               take;

  // register is free when empty or being drained this cycle
  assign take = !valid_r || out_ch.ready;
  assign pop  = head.valid && take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take) begin
      valid_r <= head.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      item_r <= head.item;
    end
  end

  assign out_ch.valid   = valid_r;
  assign out_ch.payload = item_r;

endmodule
`default_nettype wire

>>> rtl/tar_stream_deframer.sv
`default_nettype none
// Channel  | Dir | Payload                                        | Handshake
// in_ch    | in  | byte_value[7:0], final_byte                    | valid/ready
// out_ch   | out | kind[1:0], value[7:0], file_size[32:0],        | valid/ready
//          |     | file_last, truncated                           |
//
// One archive byte per cycle while the result queue is not full. The front
// parser updates its counters and the octal shift-add in the accepting cycle;
// a result passes the queue and output register to out_ch, held while it stalls.
// Reset (rst_n low, synchronous) empties the queue and output register and
// returns the parser to the start of a header block.
// in_ch.ready drops only while the result queue is full.
module tar_stream_deframer #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  tsd_stream_if.sink    in_ch,
  tsd_stream_if.source  out_ch
);

  tsd_pkg::q_push_t q_push;
  tsd_pkg::q_head_t q_head;
  logic             q_full;
  logic             q_pop;

  // Front: header/data/padding parser, one result per byte at most.
  tsd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (q_push)
  );

  // Short result queue so the parser keeps taking bytes while out_ch stalls.
  tsd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .pop   (q_pop),
    .head  (q_head),
    .full  (q_full)
  );

  // Back: registered result stage driving out_ch.
  tsd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (q_head),
    .pop    (q_pop),
    .out_ch (out_ch)
  );

`ifndef NO_ASSERTIONS
  // the parser never produces a result while the queue cannot take it
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push.valid)
    else $error("result pushed into full queue");

  // header done flags last exactly when the size is zero
  a_hdr_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.payload.kind == tsd_pkg::KIND_HDR) |->
      (out_ch.payload.file_last == (out_ch.payload.file_size == '0)))
    else $error("header done last flag inconsistent with size");

  // name and end items carry no size, last or truncation flags
  a_plain_kinds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.payload.kind == tsd_pkg::KIND_NAME ||
                      out_ch.payload.kind == tsd_pkg::KIND_END)) |->
      (!out_ch.payload.file_last && !out_ch.payload.truncated &&
       out_ch.payload.file_size == '0))
    else $error("name or end item carries flags");

  // a data byte is never both last and truncated
  a_data_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.payload.kind == tsd_pkg::KIND_DATA) |->
      (!(out_ch.payload.file_last && out_ch.payload.truncated) &&
       out_ch.payload.file_size == '0))
    else $error("data item flags inconsistent");
`endif

endmodule
`default_nettype wire

>>> dv/tar_stream_deframer_tb.sv
`timescale 1ns / 100ps

module tar_stream_deframer_tb;

  // Run shape
  localparam int RANDOM_BYTES = 840;       // random archive bytes to queue
  localparam int HOLD_AT      = 12;        // result count that starts the long sink hold
  localparam int HOLD_CYCLES  = 2000;      // length of that hold
  localparam int TAIL_CYCLES  = 16;        // settle time after the last result
  localparam int CYCLE_LIMIT  = 4_000_000;

  // One queued archive byte. wait_idle makes the sender hold this item back
  // until every predicted result has been seen.
  typedef struct packed {
    logic              wait_idle;
    tsd_pkg::in_item_t item;
  } stim_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // Testbench-side drivers, known from time zero
  logic               src_valid  = 1'b0;
  tsd_pkg::in_item_t  src_item   = '0;
  logic               sink_ready = 1'b0;

  tsd_stream_if #(.payload_t(tsd_pkg::in_item_t))  in_ch  ();
  tsd_stream_if #(.payload_t(tsd_pkg::out_item_t)) out_ch ();

  assign in_ch.valid   = src_valid;
  assign in_ch.payload = src_item;
  assign out_ch.ready  = sink_ready;

  tar_stream_deframer u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Archive bytes waiting to be offered, and results predicted but not seen
  stim_t              pending_bytes[$];
  tsd_pkg::out_item_t expected_results[$];

  // Deframer state as predicted by the testbench
  tsd_pkg::phase_t arch_phase = tsd_pkg::PH_HEADER;
  logic [8:0]      blk_ofs    = '0;
  logic [32:0]     data_left  = '0;
  logic [32:0]     size_acc   = '0;
  bit              octal_live = 1'b1;
  bit              name_live  = 1'b1;

  int  mismatches   = 0;
  int  results_seen = 0;
  int  hold_left    = 0;
  bit  hold_done    = 1'b0;
  int  cycle_count  = 0;
  bit  in_fire      = 1'b0;
  int  send_gap     = 0;
  int  send_calm    = 0;
  int  rcv_gap      = 0;
  int  rcv_calm     = 0;

  // ---------------------------------------------------------------------------
  // Deframer prediction
  // ---------------------------------------------------------------------------
  task automatic clear_deframer();
    arch_phase = tsd_pkg::PH_HEADER;
    blk_ofs    = '0;
    data_left  = '0;
    size_acc   = '0;
    octal_live = 1'b1;
    name_live  = 1'b1;
  endtask

  // Advance the predicted state by one archive byte; queue the result it causes.
  task automatic step_deframer(input tsd_pkg::in_item_t it);
    tsd_pkg::out_item_t res;
    bit                 emit;
    bit                 last;
    logic [7:0]         digit;
    logic [32:0]        sz;
    res  = '0;
    emit = 1'b0;
    case (arch_phase)
      tsd_pkg::PH_HEADER: begin
        if (blk_ofs == '0 && it.byte_value == 8'h00) begin
          // zero first byte of a header block: end of archive
          res.kind   = tsd_pkg::KIND_END;
          emit       = 1'b1;
          arch_phase = tsd_pkg::PH_DONE;
        end else begin
          if (blk_ofs < tsd_pkg::NAME_LEN && name_live) begin
            if (it.byte_value == 8'h00) begin
              name_live = 1'b0;
            end else begin
              res.kind  = tsd_pkg::KIND_NAME;
              res.value = it.byte_value;
              emit      = 1'b1;
            end
          end
          // size field: octal shift-add, closed by the first non-octal byte
          if (blk_ofs >= tsd_pkg::SIZE_OFS && blk_ofs < tsd_pkg::SIZE_END && octal_live) begin
            if (it.byte_value >= tsd_pkg::CHAR_ZERO &&
                it.byte_value <= tsd_pkg::CHAR_SEVEN) begin
              digit    = it.byte_value - tsd_pkg::CHAR_ZERO;
              size_acc = {size_acc[29:0], digit[2:0]};
            end else begin
              octal_live = 1'b0;
            end
          end
          if (blk_ofs == tsd_pkg::LAST_OFS) begin
            sz            = size_acc;
            res           = '0;
            res.kind      = tsd_pkg::KIND_HDR;
            res.file_size = sz;
            res.file_last = (sz == '0);
            res.truncated = it.final_byte && (sz != '0);
            emit          = 1'b1;
            blk_ofs       = '0;
            size_acc      = '0;
            octal_live    = 1'b1;
            name_live     = 1'b1;
            if (sz != '0) begin
              data_left  = sz;
              arch_phase = tsd_pkg::PH_DATA;
            end
          end else begin
            blk_ofs = blk_ofs + 9'd1;
          end
        end
      end
      tsd_pkg::PH_DATA: begin
        data_left     = data_left - 33'd1;
        last          = (data_left == '0);
        res.kind      = tsd_pkg::KIND_DATA;
        res.value     = it.byte_value;
        res.file_last = last;
        res.truncated = it.final_byte && !last;
        emit          = 1'b1;
        blk_ofs       = blk_ofs + 9'd1;
        if (last) begin
          arch_phase = (blk_ofs == '0) ? tsd_pkg::PH_HEADER : tsd_pkg::PH_PAD;
        end
      end
      tsd_pkg::PH_PAD: begin
        // padding content is skipped without a look
        blk_ofs = blk_ofs + 9'd1;
        if (blk_ofs == '0) begin
          arch_phase = tsd_pkg::PH_HEADER;
        end
      end
      default: begin
        // after end of archive, everything up to the final byte is ignored
      end
    endcase
    if (emit) begin
      expected_results.insert(expected_results.size(), res);
    end
    if (it.final_byte) begin
      clear_deframer();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  task automatic queue_byte(input logic [7:0] b, input bit fin, input bit wait_idle);
    stim_t s;
    s.wait_idle       = wait_idle;
    s.item.byte_value = b;
    s.item.final_byte = fin;
    pending_bytes.insert(pending_bytes.size(), s);
  endtask

  // Build one archive (1..3 files, end marker unless a file is oversized), then
  // cut it at a random point, maybe its end, never beyond max_len bytes. Returns the number of bytes queued.
  task automatic queue_archive(input bit wait_idle, input int max_len,
                               output int n_queued);
    logic [7:0]  arch[$];
    int          hdr_ends[$];
    int          n_files, n_name, need, digits, n_data, pad, cut, r, k;
    bit          huge;
    logic [32:0] sz, tmp;
    logic [7:0]  b;
    huge    = 1'b0;
    cut     = -1;
    n_files = $urandom_range(1, 3);
    for (int f = 0; f < n_files && !huge; f++) begin
      r = $urandom_range(0, 99);
      if (r < 15)      sz = '0;
      else if (r < 70) sz = 33'($urandom_range(1, 40));
      else if (r < 80) sz = 33'($urandom_range(511, 513));
      else if (r < 90) sz = 33'($urandom_range(1, 1500));
      else if (r < 95) sz = '1;
      else             sz = {1'b1, 32'($urandom)};
      huge = (sz > 33'd2000);

      r = $urandom_range(0, 99);
      if (r < 60)      n_name = $urandom_range(1, 20);
      else if (r < 75) n_name = 99;
      else if (r < 90) n_name = 100;   // name area with no terminating zero
      else             n_name = $urandom_range(21, 98);

      need = 0;
      tmp  = sz;
      while (tmp != '0) begin
        need++;
        tmp = tmp >> 3;
      end
      digits = $urandom_range(need, 11);   // zero digits only when size is zero

      for (int ofs = 0; ofs < 512; ofs++) begin
        b = 8'($urandom_range(0, 255));
        if (ofs < 100) begin
          if (ofs < n_name)       b = 8'($urandom_range(1, 255));
          else if (ofs == n_name) b = 8'h00;
        end else if (ofs >= 124 && ofs < 135) begin
          k = ofs - 124;
          if (k < digits) begin
            tmp = sz >> (3 * (digits - 1 - k));
            b   = tsd_pkg::CHAR_ZERO + {5'b0, tmp[2:0]};
          end else if (k == digits) begin
            do b = 8'($urandom_range(0, 255));
            while (b >= tsd_pkg::CHAR_ZERO && b <= tsd_pkg::CHAR_SEVEN);
          end
        end
        arch.insert(arch.size(), b);
      end
      hdr_ends.insert(hdr_ends.size(), arch.size() - 1);

      n_data = huge ? $urandom_range(1, 60) : int'(sz);
      for (int i = 0; i < n_data; i++) begin
        arch.insert(arch.size(), 8'($urandom_range(0, 255)));
      end
      if (huge) begin
        cut = arch.size() - 1;   // input ends inside an oversized file
      end else begin
        pad = (512 - (n_data % 512)) % 512;
        for (int i = 0; i < pad; i++) begin
          arch.insert(arch.size(), 8'($urandom_range(0, 255)));
        end
      end
    end

    if (!huge) begin
      arch.insert(arch.size(), 8'h00);   // end-of-archive header
      k = $urandom_range(0, 8);
      for (int i = 0; i < k; i++) begin
        arch.insert(arch.size(), 8'($urandom_range(0, 255)));
      end
      r = $urandom_range(0, 99);
      if (r < 65)      cut = arch.size() - 1;
      else if (r < 80) cut = hdr_ends[$urandom_range(0, hdr_ends.size() - 1)];
      else             cut = $urandom_range(0, arch.size() - 1);
    end
    if (cut > max_len - 1) begin
      cut = max_len - 1;
    end

    for (int i = 0; i <= cut; i++) begin
      queue_byte(arch[i], i == cut, wait_idle && i == 0);
    end
    n_queued = cut + 1;
  endtask

  // Idle-gap draw shared by both sides: mostly none, some short, a few long,
  // and now and then a calm stretch with no idling at all.
  task automatic draw_gap(inout int calm_left, output int gap);
    int r;
    gap = 0;
    if (calm_left > 0) begin
      calm_left--;
    end else begin
      r = $urandom_range(0, 999);
      if (r < 5)        calm_left = $urandom_range(100, 300);
      else if (r < 600) gap = 0;
      else if (r < 900) gap = $urandom_range(1, 3);
      else if (r < 980) gap = $urandom_range(4, 12);
      else              gap = $urandom_range(20, 60);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sender: offers queued items at the falling edge, holds each until taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      src_valid <= 1'b0;
    end else if (src_valid && !in_fire) begin
      // item still on offer, keep it steady
    end else begin
      if (in_fire) begin
        draw_gap(send_calm, send_gap);
      end
      if (send_gap != 0) begin
        send_gap--;
        src_valid <= 1'b0;
      end else if (pending_bytes.size() != 0 &&
                   !(pending_bytes[0].wait_idle && expected_results.size() != 0)) begin
        src_valid <= 1'b1;
        src_item  <= pending_bytes[0].item;
        void'(pending_bytes.pop_front());
      end else begin
        src_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready changes at the falling edge; long hold overrides it
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n || hold_left != 0) begin
      sink_ready <= 1'b0;
    end else if (rcv_gap != 0) begin
      rcv_gap--;
      sink_ready <= 1'b0;
    end else begin
      sink_ready <= 1'b1;
      draw_gap(rcv_calm, rcv_gap);
    end
  end

  // Long sink hold, counted here: the sender keeps offering, so the result
  // queue fills and in_ch.ready has to drop.
  always @(posedge clk) begin
    if (!hold_done && results_seen >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: both handshakes sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_deframer();
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_ch.valid && in_ch.ready;
      if (in_ch.valid && in_ch.ready) begin
        step_deframer(in_ch.payload);
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: expected nothing, actual kind=%0d value=%02h size=%0d last=%0b trunc=%0b",
                   $time, out_ch.payload.kind, out_ch.payload.value,
                   out_ch.payload.file_size, out_ch.payload.file_last,
                   out_ch.payload.truncated);
        end else begin
          if (out_ch.payload.kind      !== expected_results[0].kind      ||
              out_ch.payload.value     !== expected_results[0].value     ||
              out_ch.payload.file_size !== expected_results[0].file_size ||
              out_ch.payload.file_last !== expected_results[0].file_last ||
              out_ch.payload.truncated !== expected_results[0].truncated) begin
            mismatches++;
            $display("%0t: mismatch expected kind=%0d value=%02h size=%0d last=%0b trunc=%0b",
                     $time, expected_results[0].kind, expected_results[0].value,
                     expected_results[0].file_size, expected_results[0].file_last,
                     expected_results[0].truncated);
            $display("%0t:          actual   kind=%0d value=%02h size=%0d last=%0b trunc=%0b",
                     $time, out_ch.payload.kind, out_ch.payload.value,
                     out_ch.payload.file_size, out_ch.payload.file_last,
                     out_ch.payload.truncated);
          end
          void'(expected_results.pop_front());
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still expected", $time, expected_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int queued, n;
    queued = 0;

    // Directed: end of archive at once, ignored bytes after it, names cut
    // short by the final byte, value extremes inside the name area.
    queue_byte(8'h00, 1'b1, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);
    queue_byte(8'hFF, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b1, 1'b0);
    queue_byte(8'hFF, 1'b1, 1'b0);
    queue_byte(8'h01, 1'b0, 1'b0);
    queue_byte(8'h80, 1'b0, 1'b0);
    queue_byte(8'h7F, 1'b0, 1'b0);
    queue_byte(8'h00, 1'b0, 1'b0);   // name closed, later bytes are not names
    queue_byte(8'h55, 1'b1, 1'b0);

    // Random: mostly well-formed archives, some short noise runs. An archive
    // queued first and a few later ones wait until the block has drained.
    while (queued < RANDOM_BYTES) begin
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 40);
        for (int i = 0; i < n; i++) begin
          queue_byte(8'($urandom_range(0, 255)), i == n - 1, 1'b0);
        end
      end else begin
        queue_archive(queued == 0 || $urandom_range(0, 7) == 0, RANDOM_BYTES - queued, n);
      end
      queued += n;
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (pending_bytes.size() != 0 || src_valid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (expected_results.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_results.size());
    end
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/tsd_pkg.sv
rtl/tsd_stream_if.sv
rtl/tsd_front.sv
rtl/tsd_queue.sv
rtl/tsd_back.sv
rtl/tar_stream_deframer.sv
dv/tar_stream_deframer_tb.sv
